// ===== src/pee_pkg.sv =====
`timescale 1ns / 1ps

package pee_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned STATUS_W = 3;
	// output word: value, status, then zero fill to whole bytes
	localparam int unsigned OUT_W = 40;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CHAR_W-1:0] char_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_BADCHAR   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// per-cell move: keep, take the neighbor above, take the neighbor below
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

	// ASCII characters of interest
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_STAR  = 8'h2A;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_SPACE = 8'h20;

endpackage

// ===== src/pee_cell.sv =====
`timescale 1ns / 1ps

module pee_cell
	import pee_pkg::*;
(
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  word_t     from_up,
	input  word_t     from_down,
	output word_t     q
);

	word_t entry_q;

	// one stack entry; shifts toward the bottom on push, toward the top on pop
	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_PUSH: entry_q <= from_up;
			CELL_POP:  entry_q <= from_down;
			default:   entry_q <= entry_q;
		endcase
	end

	assign q = entry_q;

endmodule

// ===== src/pee_alu.sv =====
`timescale 1ns / 1ps

module pee_alu
	import pee_pkg::*;
(
	input  alu_op_t op,
	input  word_t   a,
	input  word_t   b,
	output word_t   r
);

	logic [2*WORD_W-1:0] prod;

	assign prod = a * b;

	// wrapping two's complement arithmetic on the two top entries
	always_comb begin
		unique case (op)
			ALU_ADD: r = a + b;
			ALU_SUB: r = a - b;
			ALU_MUL: r = prod[WORD_W-1:0];
			default: r = a + b;
		endcase
	end

endmodule

// ===== src/postfix_expression_evaluator_core.sv =====
// Postfix expression evaluator: one character word accepted per cycle while the
// output buffer has room. The result word is registered when the word flagged
// tlast is taken. The stack is a row of STACK_DEPTH shift cells; the top two
// cells feed one ALU. A two-entry output buffer keeps input flowing while a
// result waits. arst_n clears count, error and valid flags.
`timescale 1ns / 1ps

module postfix_expression_evaluator_core
	import pee_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,  // [7:0] char_code
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata   // [31:0] value, [34:32] status, [39:35] zero
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] TWO_CNT = CW'(2);

	logic [CW-1:0] count_q, count_next;
	status_t       err_q, err_next;

	word_t     stage_val [STACK_DEPTH];
	cell_cmd_t rest_cmd;
	cell_cmd_t top_cmd;
	word_t     top_in;

	char_t   ch;
	logic    is_space, is_digit, is_op;
	logic    fire, active, do_push, do_op;
	word_t   digit_val, alu_r, top_next;
	alu_op_t alu_op;
	status_t res_status;
	word_t   res_value;

	// output buffer: main and skid entries
	logic    main_valid_q, skid_valid_q;
	word_t   main_value_q, skid_value_q;
	status_t main_status_q, skid_status_q;
	logic    res_push, res_pop;

	// character decode
	assign ch = s_tdata;
	assign is_space = (ch == CH_SPACE);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_op = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR);
	assign digit_val = word_t'(ch - CH_ZERO);

	assign s_tready = !skid_valid_q;
	assign fire = s_tvalid && s_tready;
	assign active = fire && (err_q == ST_OK);
	assign do_push = active && is_digit && (count_q != FULL_CNT);
	assign do_op = active && is_op && (count_q >= TWO_CNT);

	always_comb begin
		priority if (ch == CH_PLUS) begin
			alu_op = ALU_ADD;
		end else if (ch == CH_MINUS) begin
			alu_op = ALU_SUB;
		end else begin
			alu_op = ALU_MUL;
		end
	end

	pee_alu u_alu (
		.op (alu_op),
		.a  (stage_val[1]),
		.b  (stage_val[0]),
		.r  (alu_r)
	);

	// cell moves: the top cell loads a digit or the ALU result
	always_comb begin
		top_cmd = (do_push || do_op) ? CELL_PUSH : CELL_HOLD;
		top_in = do_push ? digit_val : alu_r;
		priority if (do_push) begin
			rest_cmd = CELL_PUSH;
		end else if (do_op) begin
			rest_cmd = CELL_POP;
		end else begin
			rest_cmd = CELL_HOLD;
		end
	end

	// the stack as a row of shift cells, top at index 0
	generate
		for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stack
			if (i == 0) begin : g_top
				pee_cell u_stage (
					.clk       (clk),
					.cmd       (top_cmd),
					.from_up   (top_in),
					.from_down (stage_val[1]),
					.q         (stage_val[0])
				);
			end else if (i == STACK_DEPTH - 1) begin : g_bottom
				pee_cell u_stage (
					.clk       (clk),
					.cmd       (rest_cmd),
					.from_up   (stage_val[i-1]),
					.from_down ('0),
					.q         (stage_val[i])
				);
			end else begin : g_mid
				pee_cell u_stage (
					.clk       (clk),
					.cmd       (rest_cmd),
					.from_up   (stage_val[i-1]),
					.from_down (stage_val[i+1]),
					.q         (stage_val[i])
				);
			end
		end
	endgenerate

	// count and sticky error after this character
	always_comb begin
		priority if (do_push) begin
			count_next = count_q + CW'(1);
		end else if (do_op) begin
			count_next = count_q - CW'(1);
		end else begin
			count_next = count_q;
		end

		err_next = err_q;
		if (active) begin
			priority if (is_space) begin
				err_next = ST_OK;
			end else if (is_digit) begin
				err_next = (count_q == FULL_CNT) ? ST_OVERFLOW : ST_OK;
			end else if (is_op) begin
				err_next = (count_q < TWO_CNT) ? ST_UNDERFLOW : ST_OK;
			end else begin
				err_next = ST_BADCHAR;
			end
		end

		top_next = do_push ? digit_val : (do_op ? alu_r : stage_val[0]);
	end

	// result of an expression end
	always_comb begin
		priority if (err_next != ST_OK) begin
			res_status = err_next;
		end else if (count_next == '0) begin
			res_status = ST_EMPTY;
		end else begin
			res_status = ST_OK;
		end
		res_value = (res_status == ST_OK) ? top_next : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q <= ST_OK;
		end else if (fire) begin
			if (s_tlast) begin
				count_q <= '0;
				err_q <= ST_OK;
			end else begin
				count_q <= count_next;
				err_q <= err_next;
			end
		end
	end

	// output buffer control
	assign res_push = fire && s_tlast;
	assign res_pop = main_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || res_pop) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= res_push;
			end
		end else if (res_push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || res_pop) begin
			if (skid_valid_q) begin
				main_value_q <= skid_value_q;
				main_status_q <= skid_status_q;
			end else if (res_push) begin
				main_value_q <= res_value;
				main_status_q <= res_status;
			end
		end else if (res_push) begin
			skid_value_q <= res_value;
			skid_status_q <= res_status;
		end
	end

	assign m_tvalid = main_valid_q;
	assign m_tdata = {(OUT_W - WORD_W - STATUS_W)'(0), main_status_q, main_value_q};

endmodule
